FILE: rtl/alarm_chirp_flash_sequencer_unit_defines.svh
// Assertion macros for the alarm chirp and flash sequencer checker.
// Needs clk and rst_n in the scope where a macro is used.
`ifndef ALARM_CHIRP_FLASH_SEQUENCER_UNIT_DEFINES_SVH
`define ALARM_CHIRP_FLASH_SEQUENCER_UNIT_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted
`define ACFS_CHECK_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted
`define ACFS_CHECK_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: rtl/acfs_pkg.sv
// Shared types and constants for the alarm chirp and flash sequencer.
// No dependencies; imported by every module of the block but acfs_queue.
`default_nettype none

package acfs_pkg;

    // Stream widths (payload packed from bit 0, padded to whole bytes)
    localparam int IN_W     = 40;
    localparam int OUT_W    = 128;
    localparam int COLOUR_W = 24;
    localparam int NUM_LEDS = 5;
    localparam int OUT_PAD  = OUT_W - (2 + NUM_LEDS * COLOUR_W);

    // LED slots
    localparam int LED_PUMP1 = 0;
    localparam int LED_RELAY = 1;
    localparam int LED_PUMP2 = 2;
    localparam int LED_ALARM = 3;
    localparam int LED_EXT   = 4;

    // Deadline timers
    localparam int T_ALARM    = 0;
    localparam int T_CYCLE    = 1;
    localparam int T_CHIRP    = 2;
    localparam int T_FLASH    = 3;
    localparam int T_JUST     = 4;
    localparam int NUM_TIMERS = 5;

    typedef logic [COLOUR_W-1:0] colour_t;

    // Configuration register indexes
    typedef enum logic [2:0] {
        REG_INT_BRIGHT = 3'd0,
        REG_EXT_BRIGHT = 3'd1,
        REG_CHIRP_MS   = 3'd2,
        REG_FLASH_MS   = 3'd3,
        REG_CYCLE_GAP  = 3'd4,
        REG_ALARM_GAP  = 3'd5,
        REG_CRIT_COUNT = 3'd6
    } cfg_reg_t;

    typedef struct packed {
        logic [7:0]  int_bright;
        logic [7:0]  ext_bright;
        logic [15:0] chirp_ms;
        logic [15:0] flash_ms;
        logic [15:0] cycle_gap_ms;
        logic [15:0] alarm_gap_ms;
        logic [3:0]  critical_count;
    } cfg_t;

    localparam cfg_t CFG_RESET = '{
        int_bright:     8'd128,
        ext_bright:     8'd128,
        chirp_ms:       16'd10,
        flash_ms:       16'd300,
        cycle_gap_ms:   16'd600,
        alarm_gap_ms:   16'd8000,
        critical_count: 4'd5
    };

    // Pump flags, primary pump in bit 0
    typedef struct packed {
        logic relay_on;
        logic pump2_on;
        logic pump1_on;
    } pump_flags_t;

    // Alarm flags, any-alarm in bit 0
    typedef struct packed {
        logic critical;
        logic emergency;
        logic suppressed;
        logic any;
    } alarm_flags_t;

    localparam int FLAGS_W = $bits(pump_flags_t) + $bits(alarm_flags_t);

    // Unscaled result of one tick
    typedef struct packed {
        logic                      buzzer;
        colour_t [NUM_LEDS-1:0]    raw;
        logic                      show;
    } res_t;

endpackage

`default_nettype wire

FILE: rtl/acfs_front.sv
// Front end: unpacks a tick transaction and precomputes every deadline sum.
// Depends on acfs_pkg.
`default_nettype none

module acfs_front
    import acfs_pkg::*;
#(
    parameter int TIME_BITS = 32
)
(
    input  wire logic [IN_W-1:0]                        tick_data,
    input  wire cfg_t                                   cfg,
    output logic [TIME_BITS-1:0]                        now,
    output pump_flags_t                                 pumps,
    output alarm_flags_t                                alarms,
    output logic [NUM_TIMERS-1:0][TIME_BITS-1:0]        sums
);

    logic [TIME_BITS-1:0] chirp_t;
    logic [TIME_BITS-1:0] flash_t;
    logic [TIME_BITS-1:0] cycle_t;
    logic [TIME_BITS-1:0] alarm_t;

    // Field unpack: now_ms in bits 31:0, flags above
    assign now    = TIME_BITS'(tick_data[31:0]);
    assign pumps  = '{relay_on: tick_data[34], pump2_on: tick_data[33],
                      pump1_on: tick_data[32]};
    assign alarms = '{critical: tick_data[38], emergency: tick_data[37],
                      suppressed: tick_data[36], any: tick_data[35]};

    assign chirp_t = TIME_BITS'(cfg.chirp_ms);
    assign flash_t = TIME_BITS'(cfg.flash_ms);
    assign cycle_t = TIME_BITS'(cfg.cycle_gap_ms);
    assign alarm_t = TIME_BITS'(cfg.alarm_gap_ms);

    // Deadlines modulo 2^TIME_BITS
    assign sums[T_ALARM] = now + alarm_t;
    assign sums[T_CYCLE] = now + cycle_t;
    assign sums[T_CHIRP] = now + chirp_t;
    assign sums[T_FLASH] = now + flash_t;
    assign sums[T_JUST]  = now + cycle_t - flash_t;

endmodule

`default_nettype wire

FILE: rtl/acfs_queue.sv
// Small register FIFO between front end and sequencer.
// Depends on nothing; DEPTH entries of WIDTH bits.
`default_nettype none

module acfs_queue
#(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
)
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             push_valid,
    output logic                  push_ready,
    input  wire logic [WIDTH-1:0] push_data,
    output logic                  pop_valid,
    input  wire logic             pop_ready,
    output logic [WIDTH-1:0]      pop_data
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
    localparam logic [PTR_W:0]   FULL_CNT = (PTR_W + 1)'(DEPTH);
    localparam logic [PTR_W-1:0] PTR_ONE  = PTR_W'(1);
    localparam logic [PTR_W:0]   CNT_ONE  = (PTR_W + 1)'(1);

    logic [WIDTH-1:0] entry_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_next;
    logic [PTR_W:0]   count_reg;
    logic [PTR_W:0]   count_next;
    logic             push;
    logic             pop;

    assign push_ready = (count_reg != FULL_CNT);
    assign pop_valid  = (count_reg != '0);
    assign pop_data   = entry_reg[rd_ptr_reg];
    assign push       = push_valid && push_ready;
    assign pop        = pop_valid && pop_ready;

    // Pointer and fill count update
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + PTR_ONE;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + PTR_ONE;
        end
        if (push && !pop)
        begin
            count_next = count_reg + CNT_ONE;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - CNT_ONE;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Entry storage, no reset needed
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

`default_nettype wire

FILE: rtl/acfs_back.sv
// Sequencer: keeps flags, timers and raw colours, and steps them per tick.
// Depends on acfs_pkg; result leaves through a one-entry output register.
`default_nettype none

module acfs_back
    import acfs_pkg::*;
#(
    parameter int TIME_BITS = 32
)
(
    input  wire logic                                   clk,
    input  wire logic                                   rst_n,
    input  wire cfg_t                                   cfg,
    input  wire logic                                   in_valid,
    output logic                                        in_ready,
    input  wire logic [TIME_BITS-1:0]                   now,
    input  wire pump_flags_t                            pumps,
    input  wire alarm_flags_t                           alarms,
    input  wire logic [NUM_TIMERS-1:0][TIME_BITS-1:0]   sums,
    output logic                                        res_valid,
    input  wire logic                                   res_ready,
    output res_t                                        res
);

    localparam colour_t C_BLACK   = 24'h000000;
    localparam colour_t C_RED     = 24'hff0000;
    localparam colour_t C_GREEN   = 24'h00ff00;
    localparam colour_t C_BLUE    = 24'h0000ff;
    localparam colour_t C_MAGENTA = 24'hff00ff;

    pump_flags_t                          pump_reg,      pump_next;
    alarm_flags_t                         alarm_reg,     alarm_next;
    colour_t                              ext_reg,       ext_next;
    colour_t                              prev_ext_reg,  prev_ext_next;
    logic                                 sounding_reg,  sounding_next;
    logic                                 emerg_reg,     emerg_next;
    logic [3:0]                           burst_len_reg, burst_len_next;
    logic [3:0]                           burst_idx_reg, burst_idx_next;
    logic [NUM_TIMERS-1:0][TIME_BITS-1:0] dl_reg,        dl_next;
    colour_t [NUM_LEDS-1:0]               raw_reg,       raw_next;
    logic                                 buzz_reg,      buzz_next;
    res_t                                 res_reg,       res_next;
    logic                                 res_valid_reg, res_valid_next;
    logic                                 show;
    logic                                 chirps;
    logic [4:0]                           burst_inc;
    logic                                 pop;

    assign in_ready  = !res_valid_reg || res_ready;
    assign pop       = in_valid && in_ready;
    assign res_valid = res_valid_reg;
    assign res       = res_reg;

    // One tick: flag changes first, then timers in fixed order
    always_comb
    begin
        pump_next      = pump_reg;
        alarm_next     = alarm_reg;
        ext_next       = ext_reg;
        prev_ext_next  = prev_ext_reg;
        sounding_next  = sounding_reg;
        emerg_next     = emerg_reg;
        burst_len_next = burst_len_reg;
        burst_idx_next = burst_idx_reg;
        dl_next        = dl_reg;
        raw_next       = raw_reg;
        buzz_next      = buzz_reg;
        show           = 1'b0;
        chirps         = 1'b0;
        burst_inc      = '0;

        // Pump or relay change
        if (pumps != pump_reg)
        begin
            pump_next           = pumps;
            raw_next[LED_PUMP1] = pumps.pump1_on ? C_BLUE : C_BLACK;
            raw_next[LED_PUMP2] = pumps.pump2_on ? C_RED : C_BLACK;
            raw_next[LED_RELAY] = pumps.relay_on ? C_GREEN : C_BLACK;
            ext_next = pumps.pump2_on ? C_RED :
                       pumps.relay_on ? C_GREEN :
                       pumps.pump1_on ? C_BLUE : C_BLACK;
            show = 1'b1;
        end

        // External LED follows a new base colour
        if (prev_ext_reg != ext_next)
        begin
            prev_ext_next     = ext_next;
            raw_next[LED_EXT] = ext_next;
            show              = 1'b1;
        end

        // Alarm flag change restarts all timers
        if (alarms != alarm_reg)
        begin
            alarm_next     = alarms;
            sounding_next  = alarms.any && !alarms.suppressed;
            emerg_next     = alarms.emergency;
            burst_len_next = alarms.emergency ? 4'd0 :
                             alarms.critical  ? cfg.critical_count : 4'd1;
            burst_idx_next = '0;
            buzz_next      = sounding_next;
            raw_next[LED_ALARM] = (alarms != '0) ? C_MAGENTA : C_BLACK;
            raw_next[LED_EXT]   = sounding_next ? C_MAGENTA : ext_next;
            chirps          = sounding_next && !emerg_next;
            dl_next[T_JUST]  = '0;
            dl_next[T_ALARM] = chirps ? sums[T_ALARM] : '0;
            dl_next[T_CYCLE] = chirps ? sums[T_CYCLE] : '0;
            dl_next[T_CHIRP] = chirps ? sums[T_CHIRP] : '0;
            dl_next[T_FLASH] = sounding_next ? sums[T_FLASH] : '0;
            show = 1'b1;
        end

        // Chirp off
        if ((dl_next[T_CHIRP] != '0) && (now > dl_next[T_CHIRP]))
        begin
            buzz_next        = 1'b0;
            dl_next[T_CHIRP] = '0;
        end

        // Flash off; emergency schedules the next flash
        if ((dl_next[T_FLASH] != '0) && (now > dl_next[T_FLASH]))
        begin
            raw_next[LED_EXT] = ext_next;
            dl_next[T_FLASH]  = '0;
            if (emerg_next)
            begin
                dl_next[T_JUST] = sums[T_JUST];
            end
            show = 1'b1;
        end

        // Flash restart
        if ((dl_next[T_JUST] != '0) && (now > dl_next[T_JUST]))
        begin
            dl_next[T_JUST]   = '0;
            raw_next[LED_EXT] = C_MAGENTA;
            dl_next[T_FLASH]  = sums[T_FLASH];
            show = 1'b1;
        end

        // Next chirp within a burst
        if ((dl_next[T_CYCLE] != '0) && (now > dl_next[T_CYCLE]))
        begin
            burst_inc = {1'b0, burst_idx_next} + 5'd1;
            if (emerg_next || (burst_inc >= {1'b0, burst_len_next}))
            begin
                burst_idx_next   = '0;
                dl_next[T_CYCLE] = '0;
            end
            else
            begin
                burst_idx_next    = burst_inc[3:0];
                buzz_next         = 1'b1;
                raw_next[LED_EXT] = C_MAGENTA;
                dl_next[T_CYCLE]  = sums[T_CYCLE];
                dl_next[T_CHIRP]  = sums[T_CHIRP];
                dl_next[T_FLASH]  = sums[T_FLASH];
                show = 1'b1;
            end
        end

        // Alarm repeat starts a new burst
        if ((dl_next[T_ALARM] != '0) && (now > dl_next[T_ALARM]))
        begin
            buzz_next         = 1'b1;
            raw_next[LED_EXT] = C_MAGENTA;
            dl_next[T_ALARM]  = sums[T_ALARM];
            burst_idx_next    = '0;
            dl_next[T_CYCLE]  = sums[T_CYCLE];
            dl_next[T_CHIRP]  = sums[T_CHIRP];
            dl_next[T_FLASH]  = sums[T_FLASH];
            show = 1'b1;
        end

        res_next.buzzer = buzz_next;
        res_next.raw    = raw_next;
        res_next.show   = show;
    end

    // Output register occupancy
    always_comb
    begin
        res_valid_next = res_valid_reg;
        if (pop)
        begin
            res_valid_next = 1'b1;
        end
        else if (res_ready)
        begin
            res_valid_next = 1'b0;
        end
    end

    // Sequencer state, updated once per consumed transaction
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pump_reg      <= '0;
            alarm_reg     <= '0;
            ext_reg       <= C_BLACK;
            prev_ext_reg  <= C_BLACK;
            sounding_reg  <= 1'b0;
            emerg_reg     <= 1'b0;
            burst_len_reg <= '0;
            burst_idx_reg <= '0;
            dl_reg        <= '0;
            raw_reg       <= '0;
            buzz_reg      <= 1'b0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            res_valid_reg <= res_valid_next;
            if (pop)
            begin
                pump_reg      <= pump_next;
                alarm_reg     <= alarm_next;
                ext_reg       <= ext_next;
                prev_ext_reg  <= prev_ext_next;
                sounding_reg  <= sounding_next;
                emerg_reg     <= emerg_next;
                burst_len_reg <= burst_len_next;
                burst_idx_reg <= burst_idx_next;
                dl_reg        <= dl_next;
                raw_reg       <= raw_next;
                buzz_reg      <= buzz_next;
            end
        end
    end

    // Result payload
    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            res_reg <= res_next;
        end
    end

endmodule

`default_nettype wire

FILE: rtl/acfs_scale.sv
// Output stage: scales raw colours by brightness and holds the result beat.
// Depends on acfs_pkg.
`default_nettype none

module acfs_scale
    import acfs_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire cfg_t              cfg,
    input  wire logic              in_valid,
    output logic                   in_ready,
    input  wire res_t              res,
    output logic                   out_valid,
    input  wire logic              out_ready,
    output logic [OUT_W-1:0]       out_data
);

    // Each byte becomes (b * bright + 255) / 256
    function automatic colour_t scale_colour(colour_t c, logic [7:0] bright);
        logic [16:0] prod;
        colour_t     r;
        r = '0;
        for (int j = 0; j < 3; j++)
        begin
            prod = {9'd0, c[8*j +: 8]} * {9'd0, bright} + 17'd255;
            r[8*j +: 8] = prod[15:8];
        end
        return r;
    endfunction

    colour_t [NUM_LEDS-1:0] scaled;
    logic [OUT_W-1:0]       data_reg;
    logic [OUT_W-1:0]       data_next;
    logic                   valid_reg;
    logic                   valid_next;
    logic                   load;

    assign in_ready  = !valid_reg || out_ready;
    assign load      = in_valid && in_ready;
    assign out_valid = valid_reg;
    assign out_data  = data_reg;

    // Brightness scaling, internal LEDs share one setting
    always_comb
    begin
        for (int i = 0; i < NUM_LEDS; i++)
        begin
            scaled[i] = scale_colour(res.raw[i],
                                     (i == LED_EXT) ? cfg.ext_bright : cfg.int_bright);
        end
        data_next = {{OUT_PAD{1'b0}}, res.show, scaled, res.buzzer};
    end

    always_comb
    begin
        valid_next = valid_reg;
        if (load)
        begin
            valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            data_reg <= data_next;
        end
    end

endmodule

`default_nettype wire

FILE: rtl/alarm_chirp_flash_sequencer_unit.sv
// Alarm chirp and flash sequencer, top level: config registers and pipeline.
// Depends on acfs_pkg, acfs_front, acfs_queue, acfs_back and acfs_scale.
//
// Takes one tick transaction per clock and returns exactly one result
// transaction per tick, in order. Throughput is one tick per cycle when the
// output side keeps up; a result is offered on m_tvalid once its tick has
// passed the queue entry, the sequencer result register and the scaling
// output register, later while the output side stalls.
// The sequencer state step (flag compares and five deadline compares in
// priority order) is one combinational path, which sets the clock limit.
// Configuration writes take effect on the next edge and belong between
// bursts of traffic, when the pipeline is empty.
`default_nettype none

module alarm_chirp_flash_sequencer_unit
    import acfs_pkg::*;
#(
    parameter int TIME_BITS = 32
)
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    // configuration write port
    input  wire logic              cfg_we,
    input  wire logic [2:0]        cfg_index,
    input  wire logic [15:0]       cfg_wdata,
    // tick input
    input  wire logic              s_tvalid,
    output logic                   s_tready,
    // bits: now_ms[31:0], pump1_on, pump2_on, relay_on, alarm_any,
    //       alarm_suppressed, alarm_emergency, alarm_critical, zero pad
    input  wire logic [IN_W-1:0]   s_tdata,
    // result output
    output logic                   m_tvalid,
    input  wire logic              m_tready,
    // bits: buzzer, led_pump1[24], led_relay[24], led_pump2[24],
    //       led_alarm[24], led_external[24], refresh, zero pad
    output logic [OUT_W-1:0]       m_tdata
);

    localparam int Q_W = FLAGS_W + (1 + NUM_TIMERS) * TIME_BITS;

    cfg_t                                 cfg_reg;
    cfg_t                                 cfg_next;
    logic [TIME_BITS-1:0]                 f_now;
    pump_flags_t                          f_pumps;
    alarm_flags_t                         f_alarms;
    logic [NUM_TIMERS-1:0][TIME_BITS-1:0] f_sums;
    logic [Q_W-1:0]                       q_in;
    logic [Q_W-1:0]                       q_out;
    logic                                 q_valid;
    logic                                 q_ready;
    logic [TIME_BITS-1:0]                 b_now;
    pump_flags_t                          b_pumps;
    alarm_flags_t                         b_alarms;
    logic [NUM_TIMERS-1:0][TIME_BITS-1:0] b_sums;
    logic                                 r_valid;
    logic                                 r_ready;
    res_t                                 r_data;

    // Configuration register file
    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            case (cfg_reg_t'(cfg_index))
                REG_INT_BRIGHT: cfg_next.int_bright     = cfg_wdata[7:0];
                REG_EXT_BRIGHT: cfg_next.ext_bright     = cfg_wdata[7:0];
                REG_CHIRP_MS:   cfg_next.chirp_ms       = cfg_wdata;
                REG_FLASH_MS:   cfg_next.flash_ms       = cfg_wdata;
                REG_CYCLE_GAP:  cfg_next.cycle_gap_ms   = cfg_wdata;
                REG_ALARM_GAP:  cfg_next.alarm_gap_ms   = cfg_wdata;
                REG_CRIT_COUNT: cfg_next.critical_count = cfg_wdata[3:0];
                default:        cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= CFG_RESET;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    // Front end: unpack and deadline sums
    acfs_front #(
        .TIME_BITS (TIME_BITS)
    ) u_front (
        .tick_data (s_tdata),
        .cfg       (cfg_reg),
        .now       (f_now),
        .pumps     (f_pumps),
        .alarms    (f_alarms),
        .sums      (f_sums)
    );

    assign q_in = {f_pumps, f_alarms, f_now, f_sums};

    // Decoupling queue
    acfs_queue #(
        .WIDTH (Q_W),
        .DEPTH (2)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (s_tvalid),
        .push_ready (s_tready),
        .push_data  (q_in),
        .pop_valid  (q_valid),
        .pop_ready  (q_ready),
        .pop_data   (q_out)
    );

    assign {b_pumps, b_alarms, b_now, b_sums} = q_out;

    // Sequencer
    acfs_back #(
        .TIME_BITS (TIME_BITS)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .in_valid  (q_valid),
        .in_ready  (q_ready),
        .now       (b_now),
        .pumps     (b_pumps),
        .alarms    (b_alarms),
        .sums      (b_sums),
        .res_valid (r_valid),
        .res_ready (r_ready),
        .res       (r_data)
    );

    // Brightness scaling and output register
    acfs_scale u_scale (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .in_valid  (r_valid),
        .in_ready  (r_ready),
        .res       (r_data),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_data  (m_tdata)
    );

endmodule

`default_nettype wire

FILE: rtl/acfs_checker.sv
// Port-level checker for the alarm chirp and flash sequencer, bound to the top.
// Depends on acfs_pkg and alarm_chirp_flash_sequencer_unit_defines.svh.
`default_nettype none

`include "alarm_chirp_flash_sequencer_unit_defines.svh"

module acfs_checker
    import acfs_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              s_tvalid,
    input  wire logic              s_tready,
    input  wire logic              m_tvalid,
    input  wire logic              m_tready,
    input  wire logic [OUT_W-1:0]  m_tdata
);

    // Queue, sequencer result register and output register
    localparam logic [2:0] MAX_INFLIGHT = 3'd4;

    logic [2:0] inflight_reg;
    logic [2:0] inflight_next;
    logic       in_xact;
    logic       out_xact;

    assign in_xact  = s_tvalid && s_tready;
    assign out_xact = m_tvalid && m_tready;

    // Transactions accepted but not yet delivered
    always_comb
    begin
        inflight_next = inflight_reg;
        if (in_xact && !out_xact)
        begin
            inflight_next = inflight_reg + 3'd1;
        end
        else if (out_xact && !in_xact)
        begin
            inflight_next = inflight_reg - 3'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            inflight_reg <= '0;
        end
        else
        begin
            inflight_reg <= inflight_next;
        end
    end

    `ACFS_CHECK_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata), "result changed while stalled")

    `ACFS_CHECK_NOW(a_no_phantom, m_tvalid, inflight_reg != 3'd0, "result without an outstanding tick")

    `ACFS_CHECK_NOW(a_bounded, 1'b1, inflight_reg <= MAX_INFLIGHT, "more ticks in flight than storage holds")

    `ACFS_CHECK_NOW(a_pad_zero, m_tvalid, m_tdata[OUT_W-1 -: OUT_PAD] == '0, "result padding not zero")

endmodule

bind alarm_chirp_flash_sequencer_unit acfs_checker u_acfs_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

`default_nettype wire

FILE: bench/testbench.sv
`timescale 1ns / 100ps
// Self-checking bench for alarm_chirp_flash_sequencer_unit: directed ticks, then
// randomized tick streams under several register settings, checked by a predictor.
// Depends on acfs_pkg and the unit's RTL only.

module testbench
    import acfs_pkg::*;
();

    localparam int      CYCLE_LIMIT    = 400000;
    localparam int      PHASES         = 6;
    localparam int      PHASE_TICKS    = 250;
    localparam int      DRAIN_CYCLES   = 8;
    localparam int      IDLE_PCT       = 29;
    localparam int      HOLD_CYCLES    = 80;
    localparam logic [2:0] CFG_UNUSED_IDX = 3'd7;

    localparam colour_t COL_RED     = 24'hff0000;
    localparam colour_t COL_GREEN   = 24'h00ff00;
    localparam colour_t COL_BLUE    = 24'h0000ff;
    localparam colour_t COL_MAGENTA = 24'hff00ff;

    // one tick transaction, laid out as on s_tdata
    typedef struct packed {
        alarm_flags_t alarms;
        pump_flags_t  pumps;
        logic [31:0]  now_ms;
    } tick_t;

    // one result transaction, laid out as on m_tdata
    typedef struct packed {
        logic    refresh;
        colour_t led_external;
        colour_t led_alarm;
        colour_t led_pump2;
        colour_t led_relay;
        colour_t led_pump1;
        logic    buzzer;
    } result_t;

    typedef struct packed {
        logic [31:0]  now_ms;
        pump_flags_t  pumps;
        alarm_flags_t alarms;
        logic         typed;
        result_t      want;
    } script_row_t;

    // results read straight off the colour table at reset brightness (0xff -> 0x80)
    localparam result_t RES_BLANK = '0;
    localparam result_t RES_PUMPS = '{refresh: 1'b1, led_external: 24'h800000,
        led_alarm: 24'h000000, led_pump2: 24'h800000, led_relay: 24'h008000,
        led_pump1: 24'h000080, buzzer: 1'b0};
    localparam result_t RES_PUMPS_HELD = '{refresh: 1'b0, led_external: 24'h800000,
        led_alarm: 24'h000000, led_pump2: 24'h800000, led_relay: 24'h008000,
        led_pump1: 24'h000080, buzzer: 1'b0};
    localparam result_t RES_PUMPS_ALARM = '{refresh: 1'b1, led_external: 24'h800080,
        led_alarm: 24'h800080, led_pump2: 24'h800000, led_relay: 24'h008000,
        led_pump1: 24'h000080, buzzer: 1'b1};

    // directed ticks at reset settings: now, pumps {relay,p2,p1}, alarms {crit,emer,supp,any}
    localparam script_row_t TICK_SCRIPT [24] = '{
        '{32'd0,         3'b000, 4'b0000, 1'b1, RES_BLANK},       // idle after reset
        '{32'd1000,      3'b111, 4'b0000, 1'b1, RES_PUMPS},       // all pumps on
        '{32'd1001,      3'b111, 4'b0000, 1'b1, RES_PUMPS_HELD},  // no change
        '{32'd1002,      3'b111, 4'b0001, 1'b1, RES_PUMPS_ALARM}, // alarm starts
        '{32'd1013,      3'b111, 4'b0001, 1'b0, RES_BLANK},       // chirp ends
        '{32'd1303,      3'b111, 4'b0001, 1'b0, RES_BLANK},       // flash ends
        '{32'd1603,      3'b111, 4'b0001, 1'b0, RES_BLANK},       // burst of one ends
        '{32'd9003,      3'b111, 4'b0001, 1'b0, RES_BLANK},       // alarm repeats
        '{32'd9010,      3'b111, 4'b0011, 1'b0, RES_BLANK},       // suppressed
        '{32'd9020,      3'b111, 4'b1001, 1'b0, RES_BLANK},       // critical burst
        '{32'd9031,      3'b111, 4'b1001, 1'b0, RES_BLANK},
        '{32'd9621,      3'b111, 4'b1001, 1'b0, RES_BLANK},       // second chirp
        '{32'd10222,     3'b111, 4'b1001, 1'b0, RES_BLANK},       // third chirp
        '{32'd10300,     3'b111, 4'b0101, 1'b0, RES_BLANK},       // emergency
        '{32'd10601,     3'b111, 4'b0101, 1'b0, RES_BLANK},       // flash off, rearm
        '{32'd10902,     3'b111, 4'b0101, 1'b0, RES_BLANK},       // flash again
        '{32'd11203,     3'b111, 4'b0101, 1'b0, RES_BLANK},
        '{32'd11300,     3'b001, 4'b0000, 1'b0, RES_BLANK},       // pump1 only, clear
        '{32'd11301,     3'b101, 4'b0000, 1'b0, RES_BLANK},       // relay beats pump1
        '{32'd11302,     3'b010, 4'b0100, 1'b0, RES_BLANK},       // emergency w/o any
        '{32'hFFFF_FFF6, 3'b000, 4'b0001, 1'b0, RES_BLANK},       // chirp sum wraps to 0
        '{32'hFFFF_FFFF, 3'b000, 4'b0001, 1'b0, RES_BLANK},       // wrapped deadlines
        '{32'd0,         3'b000, 4'b0000, 1'b0, RES_BLANK},
        '{32'h8000_0000, 3'b111, 4'b1111, 1'b0, RES_BLANK}        // every flag
    };

    logic                clk = 1'b0;
    logic                rst_n;
    logic                cfg_we;
    logic [2:0]          cfg_index;
    logic [15:0]         cfg_wdata;
    logic                s_tvalid;
    logic                s_tready;
    logic [IN_W-1:0]     s_tdata;
    logic                m_tvalid;
    logic                m_tready;
    logic [OUT_W-1:0]    m_tdata;

    // predictor state and its copy of the registers
    cfg_t          settings = CFG_RESET;
    pump_flags_t   last_pumps = '0;
    alarm_flags_t  last_alarms = '0;
    colour_t       ext_base = '0;
    colour_t       last_ext_base = '0;
    logic          alarm_sounding = 1'b0;
    logic          in_emergency = 1'b0;
    logic          buzz = 1'b0;
    logic [3:0]    burst_len = '0;
    logic [3:0]    burst_pos = '0;
    logic [31:0]   due_at [NUM_TIMERS] = '{default: '0};
    colour_t       raw [NUM_LEDS] = '{default: '0};

    result_t       due_results [$];
    tick_t         cur_tick;
    int            errors = 0;
    int            cycles = 0;
    int            tx_idle_pct = IDLE_PCT;
    int            rx_idle_pct = IDLE_PCT;
    int            stall_req = 0;

    alarm_chirp_flash_sequencer_unit DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    always #10 clk = ~clk;

    // run guard
    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("status: fail");
            $finish;
        end
    end

    // per-byte brightness scaling with round-up
    function automatic colour_t dim(input colour_t c, input logic [7:0] bright);
        colour_t r;
        int      p;
        for (int j = 0; j < 3; j++)
        begin
            p = c[8*j +: 8] * bright + 255;
            r[8*j +: 8] = p[15:8];
        end
        return r;
    endfunction

    // advance the sequencer by one tick and return its output
    function automatic result_t advance_sequencer(input tick_t t);
        logic [31:0] now;
        logic        refresh;
        logic        chirps;
        result_t     r;
        now = t.now_ms;
        refresh = 1'b0;

        // pump and relay indicators
        if (t.pumps != last_pumps)
        begin
            last_pumps = t.pumps;
            raw[LED_PUMP1] = t.pumps.pump1_on ? COL_BLUE : '0;
            raw[LED_PUMP2] = t.pumps.pump2_on ? COL_RED : '0;
            raw[LED_RELAY] = t.pumps.relay_on ? COL_GREEN : '0;
            ext_base = t.pumps.pump2_on ? COL_RED : t.pumps.relay_on ? COL_GREEN :
                       t.pumps.pump1_on ? COL_BLUE : '0;
            refresh = 1'b1;
        end
        if (last_ext_base != ext_base)
        begin
            last_ext_base = ext_base;
            raw[LED_EXT] = ext_base;
            refresh = 1'b1;
        end

        // alarm flag change restarts every timer
        if (t.alarms != last_alarms)
        begin
            last_alarms = t.alarms;
            alarm_sounding = t.alarms.any && !t.alarms.suppressed;
            in_emergency = t.alarms.emergency;
            burst_len = in_emergency ? 4'd0 :
                        t.alarms.critical ? settings.critical_count : 4'd1;
            burst_pos = '0;
            buzz = alarm_sounding;
            raw[LED_ALARM] = (t.alarms != '0) ? COL_MAGENTA : '0;
            raw[LED_EXT] = alarm_sounding ? COL_MAGENTA : ext_base;
            chirps = alarm_sounding && !in_emergency;
            due_at[T_JUST] = '0;
            due_at[T_ALARM] = chirps ? now + settings.alarm_gap_ms : '0;
            due_at[T_CYCLE] = chirps ? now + settings.cycle_gap_ms : '0;
            due_at[T_CHIRP] = chirps ? now + settings.chirp_ms : '0;
            due_at[T_FLASH] = alarm_sounding ? now + settings.flash_ms : '0;
            refresh = 1'b1;
        end

        // deadlines, in priority order
        if (due_at[T_CHIRP] != 0 && now > due_at[T_CHIRP])
        begin
            buzz = 1'b0;
            due_at[T_CHIRP] = '0;
        end
        if (due_at[T_FLASH] != 0 && now > due_at[T_FLASH])
        begin
            raw[LED_EXT] = ext_base;
            due_at[T_FLASH] = '0;
            if (in_emergency)
                due_at[T_JUST] = now + settings.cycle_gap_ms - settings.flash_ms;
            refresh = 1'b1;
        end
        if (due_at[T_JUST] != 0 && now > due_at[T_JUST])
        begin
            due_at[T_JUST] = '0;
            raw[LED_EXT] = COL_MAGENTA;
            due_at[T_FLASH] = now + settings.flash_ms;
            refresh = 1'b1;
        end
        if (due_at[T_CYCLE] != 0 && now > due_at[T_CYCLE])
        begin
            burst_pos = burst_pos + 4'd1;
            if (in_emergency || burst_pos >= burst_len)
            begin
                burst_pos = '0;
                due_at[T_CYCLE] = '0;
            end
            else
            begin
                buzz = 1'b1;
                raw[LED_EXT] = COL_MAGENTA;
                due_at[T_CYCLE] = now + settings.cycle_gap_ms;
                due_at[T_CHIRP] = now + settings.chirp_ms;
                due_at[T_FLASH] = now + settings.flash_ms;
                refresh = 1'b1;
            end
        end
        if (due_at[T_ALARM] != 0 && now > due_at[T_ALARM])
        begin
            buzz = 1'b1;
            raw[LED_EXT] = COL_MAGENTA;
            due_at[T_ALARM] = now + settings.alarm_gap_ms;
            burst_pos = '0;
            due_at[T_CYCLE] = now + settings.cycle_gap_ms;
            due_at[T_CHIRP] = now + settings.chirp_ms;
            due_at[T_FLASH] = now + settings.flash_ms;
            refresh = 1'b1;
        end

        r.buzzer       = buzz;
        r.led_pump1    = dim(raw[LED_PUMP1], settings.int_bright);
        r.led_relay    = dim(raw[LED_RELAY], settings.int_bright);
        r.led_pump2    = dim(raw[LED_PUMP2], settings.int_bright);
        r.led_alarm    = dim(raw[LED_ALARM], settings.int_bright);
        r.led_external = dim(raw[LED_EXT], settings.ext_bright);
        r.refresh      = refresh;
        return r;
    endfunction

    task automatic log_mismatch(input string msg);
        $display("mismatch at cycle %0d: %s", cycles, msg);
        errors++;
    endtask

    // compare one output transaction with the oldest expectation
    task automatic check_result(input logic [OUT_W-1:0] bus);
        result_t got;
        result_t want;
        got = bus[$bits(result_t)-1:0];
        if (due_results.size() == 0)
        begin
            log_mismatch($sformatf("unexpected result %h", got));
            return;
        end
        want = due_results.pop_front();
        if (got.buzzer !== want.buzzer)
            log_mismatch($sformatf("buzzer %b want %b", got.buzzer, want.buzzer));
        if (got.led_pump1 !== want.led_pump1)
            log_mismatch($sformatf("led_pump1 %h want %h", got.led_pump1, want.led_pump1));
        if (got.led_relay !== want.led_relay)
            log_mismatch($sformatf("led_relay %h want %h", got.led_relay, want.led_relay));
        if (got.led_pump2 !== want.led_pump2)
            log_mismatch($sformatf("led_pump2 %h want %h", got.led_pump2, want.led_pump2));
        if (got.led_alarm !== want.led_alarm)
            log_mismatch($sformatf("led_alarm %h want %h", got.led_alarm, want.led_alarm));
        if (got.led_external !== want.led_external)
            log_mismatch($sformatf("led_external %h want %h",
                                   got.led_external, want.led_external));
        if (got.refresh !== want.refresh)
            log_mismatch($sformatf("refresh %b want %b", got.refresh, want.refresh));
    endtask

    // offer one tick, wait for the transaction, record what should come out
    task automatic send_tick(input tick_t t, input logic typed, input result_t want);
        result_t predicted;
        while ($urandom_range(0, 99) < tx_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {{(IN_W - $bits(tick_t)){1'b0}}, t};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        predicted = advance_sequencer(t);
        due_results.push_back(typed ? want : predicted);
    endtask

    // register write; the caller lowers cfg_we after its last write
    task automatic write_reg(input logic [2:0] idx, input logic [15:0] data);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= data;
        @(posedge clk);
        case (idx)
            REG_INT_BRIGHT: settings.int_bright     = data[7:0];
            REG_EXT_BRIGHT: settings.ext_bright     = data[7:0];
            REG_CHIRP_MS:   settings.chirp_ms       = data;
            REG_FLASH_MS:   settings.flash_ms       = data;
            REG_CYCLE_GAP:  settings.cycle_gap_ms   = data;
            REG_ALARM_GAP:  settings.alarm_gap_ms   = data;
            REG_CRIT_COUNT: settings.critical_count = data[3:0];
            default: ;
        endcase
    endtask

    task automatic program_regs(input logic [15:0] ib, input logic [15:0] eb,
                                input logic [15:0] ch, input logic [15:0] fl,
                                input logic [15:0] cy, input logic [15:0] al,
                                input logic [15:0] cr);
        write_reg(REG_INT_BRIGHT, ib);
        write_reg(REG_EXT_BRIGHT, eb);
        write_reg(REG_CHIRP_MS, ch);
        write_reg(REG_FLASH_MS, fl);
        write_reg(REG_CYCLE_GAP, cy);
        write_reg(REG_ALARM_GAP, al);
        write_reg(REG_CRIT_COUNT, cr);
    endtask

    task automatic wait_drained;
        while (due_results.size() != 0)
            @(posedge clk);
    endtask

    // random ticks: time mostly creeps forward, flags hold for runs
    task automatic run_traffic(input int count, input int step_max, input logic hold);
        for (int n = 0; n < count; n++)
        begin
            if ($urandom_range(0, 99) < 2)
                cur_tick.now_ms = $urandom;
            else
                cur_tick.now_ms = cur_tick.now_ms + $urandom_range(0, step_max);
            if ($urandom_range(0, 99) < 6)
                cur_tick.pumps = 3'($urandom_range(0, 7));
            if ($urandom_range(0, 99) < 8)
            begin
                if ($urandom_range(0, 4) == 0)
                    cur_tick.alarms = 4'($urandom_range(0, 15));
                else if ($urandom_range(0, 3) == 0)
                    cur_tick.alarms = '0;
                else
                begin
                    cur_tick.alarms.any        = 1'b1;
                    cur_tick.alarms.suppressed = ($urandom_range(0, 5) == 0);
                    cur_tick.alarms.emergency  = ($urandom_range(0, 3) == 0);
                    cur_tick.alarms.critical   = 1'($urandom_range(0, 1));
                end
            end
            if (hold && n == 120)
                stall_req = HOLD_CYCLES;
            send_tick(cur_tick, 1'b0, RES_BLANK);
        end
        s_tvalid <= 1'b0;
    endtask

    // result side: random back-pressure plus requested long hold-offs
    initial
    begin
        int stall_left;
        stall_left = 0;
        m_tready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (m_tvalid && m_tready)
                check_result(m_tdata);
            if (stall_req > 0)
            begin
                stall_left = stall_req;
                stall_req = 0;
            end
            if (stall_left > 0)
            begin
                stall_left--;
                m_tready <= 1'b0;
            end
            else
                m_tready <= ($urandom_range(0, 99) >= rx_idle_pct);
        end
    end

    // main sequence
    initial
    begin
        tick_t t;
        rst_n     = 1'b0;
        cfg_we    = 1'b0;
        cfg_index = '0;
        cfg_wdata = '0;
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed ticks at reset settings
        foreach (TICK_SCRIPT[k])
        begin
            t.now_ms = TICK_SCRIPT[k].now_ms;
            t.pumps  = TICK_SCRIPT[k].pumps;
            t.alarms = TICK_SCRIPT[k].alarms;
            send_tick(t, TICK_SCRIPT[k].typed, TICK_SCRIPT[k].want);
        end
        cur_tick = t;
        s_tvalid <= 1'b0;

        // random phases, each under its own register setting
        for (int p = 0; p < PHASES; p++)
        begin
            wait_drained();
            repeat (DRAIN_CYCLES) @(posedge clk);
            case (p)
                0:
                begin
                    // shortest timers, bright internal, dark external
                    program_regs(16'hFFFF, 16'h0000, 16'd1, 16'd1, 16'd1, 16'd1, 16'hFFFF);
                    write_reg(CFG_UNUSED_IDX, 16'h5A5A);
                    cur_tick.now_ms = 32'd100;
                end
                1:
                begin
                    // longest timers, time runs over the top
                    program_regs(16'hFF00, 16'h00FF, 16'hFFFF, 16'hFFFF, 16'hFFFF,
                                 16'hFFFF, 16'h0001);
                    cur_tick.now_ms = 32'hFFC0_0000;
                end
                2:
                begin
                    // critical count masked down to zero
                    program_regs(16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)),
                                 16'($urandom_range(1, 20)), 16'($urandom_range(1, 60)),
                                 16'($urandom_range(1, 120)), 16'($urandom_range(100, 800)),
                                 16'h0010);
                    cur_tick.now_ms = $urandom;
                end
                default:
                begin
                    program_regs(16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)),
                                 16'($urandom_range(1, 20)), 16'($urandom_range(1, 60)),
                                 16'($urandom_range(1, 120)), 16'($urandom_range(100, 800)),
                                 16'($urandom_range(0, 65535)));
                    cur_tick.now_ms = $urandom;
                end
            endcase
            cfg_we <= 1'b0;
            @(posedge clk);

            // one phase runs without any idling on either side
            tx_idle_pct = (p == 3) ? 0 : IDLE_PCT;
            rx_idle_pct = (p == 3) ? 0 : IDLE_PCT;
            run_traffic(PHASE_TICKS, (p == 0) ? 3 : (p == 1) ? 40000 : 40,
                        (p == 2 || p == 4));
        end

        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (errors == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule

FILE: alarm_chirp_flash_sequencer_unit.f
+incdir+rtl
rtl/acfs_pkg.sv
rtl/acfs_front.sv
rtl/acfs_queue.sv
rtl/acfs_back.sv
rtl/acfs_scale.sv
rtl/alarm_chirp_flash_sequencer_unit.sv
rtl/acfs_checker.sv
bench/testbench.sv
